[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the tile visibility RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, quiet while reset is high
`define TV_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// condition that must never be seen
`define TV_ASSERT_NEVER(label, cond, msg) \
   `TV_ASSERT(label, !(cond), msg)

`endif

[design/tvis_pkg.sv]
// ----------------------------------------------------------------------------
// tvis_pkg
// Shared types and constants of the triangle tile visibility block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvis_pkg;

   localparam int COORD_W     = 24;            // vertex field width
   localparam int OPW         = 26;            // cross product operand width
   localparam int RW          = 2 * OPW + 1;   // cross product result width
   localparam int STACK_DEPTH = 19;
   localparam int SP_W        = 5;

   typedef struct packed {
      logic [2:0] lvl;
      logic [5:0] y;
      logic [5:0] x;
   } quad_type;

   // request to the shared cross product unit: a*b - c*d
   typedef struct packed {
      logic                  start;
      logic signed [OPW-1:0] a;
      logic signed [OPW-1:0] b;
      logic signed [OPW-1:0] c;
      logic signed [OPW-1:0] d;
   } xp_req_type;

   typedef struct packed {
      logic                 done;
      logic signed [RW-1:0] result;
   } xp_rsp_type;

endpackage

[design/triangle_tile_visibility.sv]
// ----------------------------------------------------------------------------
// triangle_tile_visibility
// Quadtree binning of one triangle onto a square tile map.
//
// req_* carries one triangle (three signed fixed point vertices). The block
// clears nothing up front: the map was zeroed as the previous result went
// out. It walks a quadtree from a quad stack, judging each quad with exact
// cross products on one shared multiplier, then streams MAP_SIZE rsp
// transactions, rows 0 upward, rsp_last_row on the last. req_stall stays
// high from acceptance until the last row transaction is taken. A quad
// takes up to 12 cross products for the corner tests and up to 24 more for
// the edge tests; each marked row is a read and a write of the map, and a
// split pushes the four child quads. The walk over the shared multiplier
// sets the rate: it is a single quad when the root quad is covered outright
// and many quads when long edges cut through them. Each output row is read
// and then sent; rsp_stall just holds the current row; nothing is lost.
// After reset the block zeroes every row of the map memory, req_stall high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module triangle_tile_visibility
   import tvis_pkg::*;
#(
   parameter int MAP_SIZE      = 64,
   parameter int FRACTION_BITS = 8
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_vertex_a_x,
   input  logic signed [COORD_W-1:0] req_vertex_a_y,
   input  logic signed [COORD_W-1:0] req_vertex_b_x,
   input  logic signed [COORD_W-1:0] req_vertex_b_y,
   input  logic signed [COORD_W-1:0] req_vertex_c_x,
   input  logic signed [COORD_W-1:0] req_vertex_c_y,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [5:0]                rsp_row_index,
   output logic [63:0]               rsp_row_mask,
   output logic                      rsp_last_row
);

   localparam int               ROW_W     = $clog2(MAP_SIZE);
   localparam logic [2:0]       ROOT_LVL  = 3'($clog2(MAP_SIZE));
   localparam logic [6:0]       MAP_LIM   = 7'(MAP_SIZE);
   localparam logic [64:0]      COL_LIM_W = (65'd1 << MAP_SIZE) - 65'd1;
   localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(MAP_SIZE - 1);

   // quad side lines checked against the triangle edges
   localparam logic [1:0] SIDE_Y0 = 2'd0;
   localparam logic [1:0] SIDE_Y1 = 2'd1;
   localparam logic [1:0] SIDE_X0 = 2'd2;
   localparam logic [1:0] SIDE_X1 = 2'd3;

   typedef enum logic [4:0] {
      S_CLEAR,      // post-reset sweep of the map memory
      S_IDLE,
      S_AREA,       // signed area of the triangle
      S_AREA_W,
      S_POP,
      S_CORNER,     // one edge function of one quad corner
      S_CORNER_W,
      S_DECIDE,
      S_VERT,       // triangle vertex inside quad box
      S_EDGE,       // strict crossing check, lower bound product
      S_EDGE_LO_W,
      S_EDGE_HI,    // upper bound product
      S_EDGE_HI_W,
      S_MARK_RD,
      S_MARK_WR,
      S_PUSH,
      S_OUT_RD,
      S_OUT_SEND
   } state_type;

   state_type                 state_ff;
   logic signed [COORD_W-1:0] tri_ff [6];
   quad_type                  stack_mem [STACK_DEPTH];
   logic [SP_W-1:0]           sp_ff;
   logic [5:0]                qx_ff, qy_ff;
   logic [2:0]                qlvl_ff;
   logic                      area_pos_ff, area_neg_ff;
   logic                      all_ff, one_ff, den_neg_ff;
   logic [1:0]                cn_ff, sub_ff, sd_ff, push_ff;
   logic [6:0]                mrow_ff;
   logic [63:0]               mask_ff;
   logic [ROW_W-1:0]          orow_ff;

   logic [63:0]               map_mem [MAP_SIZE];
   logic [63:0]               rd_ff;

   xp_req_type                xp_req;
   xp_rsp_type                xp_rsp;

   // ---------------------------------------------------------------------
   // Quad geometry
   // ---------------------------------------------------------------------
   function automatic logic signed [OPW-1:0] scale(input logic [6:0] c);
      return $signed({{(OPW-7){1'b0}}, c}) <<< FRACTION_BITS;
   endfunction

   logic [6:0]            size7, xe7, ye7;
   logic [5:0]            half6;
   logic signed [OPW-1:0] sx0, sx1, sy0, sy1;
   logic [64:0]           mask_w;
   logic [63:0]           quad_mask;
   quad_type              top_entry;

   always_comb begin
      size7     = 7'd1 << qlvl_ff;
      half6     = 6'(size7 >> 1);
      xe7       = 7'(qx_ff) + size7;
      ye7       = 7'(qy_ff) + size7;
      sx0       = scale(7'(qx_ff));
      sy0       = scale(7'(qy_ff));
      sx1       = scale(xe7);
      sy1       = scale(ye7);
      mask_w    = ((65'd1 << size7) - 65'd1) << qx_ff;
      quad_mask = mask_w[63:0] & COL_LIM_W[63:0];
      top_entry = stack_mem[SP_W'(sp_ff - 1'b1)];
   end

   // ---------------------------------------------------------------------
   // Vertices, rotated by sub_ff so that v0 is vertex sub, v1 the next
   // ---------------------------------------------------------------------
   logic signed [OPW-1:0] ax, ay, bx, by, cx, cy;
   logic signed [OPW-1:0] v0x, v0y, v1x, v1y, v2x, v2y;

   always_comb begin
      ax = OPW'(tri_ff[0]);
      ay = OPW'(tri_ff[1]);
      bx = OPW'(tri_ff[2]);
      by = OPW'(tri_ff[3]);
      cx = OPW'(tri_ff[4]);
      cy = OPW'(tri_ff[5]);
      case (sub_ff)
         2'd1: begin
            v0x = bx; v0y = by; v1x = cx; v1y = cy; v2x = ax; v2y = ay;
         end
         2'd2: begin
            v0x = cx; v0y = cy; v1x = ax; v1y = ay; v2x = bx; v2y = by;
         end
         default: begin
            v0x = ax; v0y = ay; v1x = bx; v1y = by; v2x = cx; v2y = cy;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Operand selection for the shared cross product unit
   // ---------------------------------------------------------------------
   logic signed [OPW-1:0] px, py;
   logic signed [OPW-1:0] ua, va, ub, vb, line_v, lo_v, hi_v, bound_v;
   logic signed [OPW-1:0] d1, d2;
   logic                  strict_x, vert_hit, edge_last;

   always_comb begin
      // evaluation point of the edge functions
      if (state_ff == S_AREA) begin
         px = ax;
         py = ay;
      end else begin
         px = (cn_ff == 2'd1 || cn_ff == 2'd2) ? sx1 : sx0;
         py = (cn_ff == 2'd2 || cn_ff == 2'd3) ? sy1 : sy0;
      end

      // edge v0-v1 against one quad side; u runs along the side
      if (sd_ff == SIDE_Y0 || sd_ff == SIDE_Y1) begin
         ua = v0x; va = v0y; ub = v1x; vb = v1y;
         line_v = (sd_ff == SIDE_Y0) ? sy0 : sy1;
         lo_v = sx0;
         hi_v = sx1;
      end else begin
         ua = v0y; va = v0x; ub = v1y; vb = v1x;
         line_v = (sd_ff == SIDE_X0) ? sx0 : sx1;
         lo_v = sy0;
         hi_v = sy1;
      end
      bound_v  = (state_ff == S_EDGE_HI) ? hi_v : lo_v;
      d1       = va - line_v;
      d2       = vb - line_v;
      strict_x = (d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0);

      vert_hit  = v0x >= sx0 && v0x <= sx1 && v0y >= sy0 && v0y <= sy1;
      edge_last = (sd_ff == SIDE_X1) && (sub_ff == 2'd2);

      xp_req.start = (state_ff == S_AREA) || (state_ff == S_CORNER) ||
                     (state_ff == S_EDGE && strict_x) || (state_ff == S_EDGE_HI);
      if (state_ff == S_EDGE || state_ff == S_EDGE_HI) begin
         // (u_b - bound) * (v_b - v_a) - (v_b - line) * (u_b - u_a)
         xp_req.a = ub - bound_v;
         xp_req.b = vb - va;
         xp_req.c = d2;
         xp_req.d = ub - ua;
      end else begin
         // edge function of v1-v2 at p
         xp_req.a = v1x - px;
         xp_req.b = v2y - py;
         xp_req.c = v2x - px;
         xp_req.d = v1y - py;
      end
   end

   tvis_xprod u_xprod (
      .clock  (clock),
      .reset  (reset),
      .xp_req (xp_req),
      .xp_rsp (xp_rsp)
   );

   logic signed [RW-1:0] res;
   logic                 res_pos, res_neg, corner_ok;

   always_comb begin
      res       = xp_rsp.result;
      res_neg   = res[RW-1];
      res_pos   = !res_neg && (res != '0);
      corner_ok = area_pos_ff ? res_pos : res_neg;
   end

   // ---------------------------------------------------------------------
   // Map memory port and stack write port
   // ---------------------------------------------------------------------
   logic                 mem_wr, mem_rd;
   logic [ROW_W-1:0]     mem_addr;
   logic [63:0]          mem_wdata;
   logic                 stk_we;
   logic [SP_W-1:0]      stk_idx;
   quad_type             stk_data;
   logic                 req_acc;

   assign req_acc = req_valid && !req_stall;

   always_comb begin
      mem_wr    = 1'b0;
      mem_rd    = 1'b0;
      mem_addr  = orow_ff;
      mem_wdata = '0;
      case (state_ff)
         S_CLEAR: mem_wr = 1'b1;
         S_OUT_RD: begin
            // read the row for output and zero it for the next triangle
            mem_rd = 1'b1;
            mem_wr = 1'b1;
         end
         S_MARK_RD: begin
            mem_rd   = 1'b1;
            mem_addr = mrow_ff[ROW_W-1:0];
         end
         S_MARK_WR: begin
            mem_wr    = 1'b1;
            mem_addr  = mrow_ff[ROW_W-1:0];
            mem_wdata = rd_ff | mask_ff;
         end
         default: ;
      endcase

      stk_we   = 1'b0;
      stk_idx  = sp_ff;
      stk_data = '{lvl: 3'(qlvl_ff - 3'd1), y: qy_ff, x: qx_ff};
      if (state_ff == S_IDLE) begin
         stk_we   = req_acc;
         stk_idx  = '0;
         stk_data = '{lvl: ROOT_LVL, y: 6'd0, x: 6'd0};
      end else if (state_ff == S_PUSH) begin
         stk_we = sp_ff < SP_W'(STACK_DEPTH);
         if (push_ff[0]) stk_data.x = qx_ff + half6;
         if (push_ff[1]) stk_data.y = qy_ff + half6;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) map_mem[mem_addr] <= mem_wdata;
      if (mem_rd) rd_ff <= map_mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stack_mem[stk_idx] <= stk_data;
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         orow_ff  <= '0;
         sp_ff    <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               orow_ff <= orow_ff + 1'b1;
               if (orow_ff == LAST_ROW) begin
                  orow_ff  <= '0;
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  tri_ff[0] <= req_vertex_a_x;
                  tri_ff[1] <= req_vertex_a_y;
                  tri_ff[2] <= req_vertex_b_x;
                  tri_ff[3] <= req_vertex_b_y;
                  tri_ff[4] <= req_vertex_c_x;
                  tri_ff[5] <= req_vertex_c_y;
                  sp_ff     <= SP_W'(1);
                  sub_ff    <= 2'd0;
                  state_ff  <= S_AREA;
               end
            end
            S_AREA: state_ff <= S_AREA_W;
            S_AREA_W: begin
               if (xp_rsp.done) begin
                  area_pos_ff <= res_pos;
                  area_neg_ff <= res_neg;
                  state_ff    <= S_POP;
               end
            end
            S_POP: begin
               if (sp_ff == '0) begin
                  orow_ff  <= '0;
                  state_ff <= S_OUT_RD;
               end else begin
                  sp_ff   <= sp_ff - 1'b1;
                  qx_ff   <= top_entry.x;
                  qy_ff   <= top_entry.y;
                  qlvl_ff <= (top_entry.lvl > 3'd6) ? 3'd6 : top_entry.lvl;
                  cn_ff   <= 2'd0;
                  sub_ff  <= 2'd0;
                  one_ff  <= 1'b0;
                  // degenerate triangle: no corner can be inside
                  if (area_pos_ff || area_neg_ff) begin
                     all_ff   <= 1'b1;
                     state_ff <= S_CORNER;
                  end else begin
                     all_ff   <= 1'b0;
                     state_ff <= S_DECIDE;
                  end
               end
            end
            S_CORNER: state_ff <= S_CORNER_W;
            S_CORNER_W: begin
               if (xp_rsp.done) begin
                  if (corner_ok && sub_ff != 2'd2) begin
                     sub_ff   <= sub_ff + 1'b1;
                     state_ff <= S_CORNER;
                  end else begin
                     all_ff <= all_ff && corner_ok;
                     one_ff <= one_ff || corner_ok;
                     sub_ff <= 2'd0;
                     cn_ff  <= cn_ff + 1'b1;
                     state_ff <= (cn_ff == 2'd3) ? S_DECIDE : S_CORNER;
                  end
               end
            end
            S_DECIDE: begin
               mask_ff <= quad_mask;
               mrow_ff <= 7'(qy_ff);
               push_ff <= 2'd0;
               sub_ff  <= 2'd0;
               sd_ff   <= SIDE_Y0;
               if (all_ff || (one_ff && qlvl_ff == 3'd0)) begin
                  state_ff <= S_MARK_RD;
               end else if (one_ff) begin
                  state_ff <= S_PUSH;
               end else begin
                  state_ff <= S_VERT;
               end
            end
            S_VERT: begin
               if (vert_hit) begin
                  state_ff <= (qlvl_ff == 3'd0) ? S_POP : S_PUSH;
               end else if (sub_ff == 2'd2) begin
                  sub_ff   <= 2'd0;
                  state_ff <= S_EDGE;
               end else begin
                  sub_ff <= sub_ff + 1'b1;
               end
            end
            S_EDGE: begin
               if (strict_x) begin
                  den_neg_ff <= vb < va;
                  state_ff   <= S_EDGE_LO_W;
               end else begin
                  if (sd_ff == SIDE_X1) sub_ff <= sub_ff + 1'b1;
                  sd_ff    <= sd_ff + 1'b1;
                  state_ff <= edge_last ? S_POP : S_EDGE;
               end
            end
            S_EDGE_LO_W: begin
               if (xp_rsp.done) begin
                  if (den_neg_ff ? !res_pos : !res_neg) begin
                     state_ff <= S_EDGE_HI;
                  end else begin
                     if (sd_ff == SIDE_X1) sub_ff <= sub_ff + 1'b1;
                     sd_ff    <= sd_ff + 1'b1;
                     state_ff <= edge_last ? S_POP : S_EDGE;
                  end
               end
            end
            S_EDGE_HI: state_ff <= S_EDGE_HI_W;
            S_EDGE_HI_W: begin
               if (xp_rsp.done) begin
                  if (den_neg_ff ? !res_neg : !res_pos) begin
                     state_ff <= (qlvl_ff == 3'd0) ? S_POP : S_PUSH;
                  end else begin
                     if (sd_ff == SIDE_X1) sub_ff <= sub_ff + 1'b1;
                     sd_ff    <= sd_ff + 1'b1;
                     state_ff <= edge_last ? S_POP : S_EDGE;
                  end
               end
            end
            S_MARK_RD: begin
               // rows past the map edge are never marked
               state_ff <= (mrow_ff >= MAP_LIM) ? S_POP : S_MARK_WR;
            end
            S_MARK_WR: begin
               mrow_ff  <= mrow_ff + 1'b1;
               state_ff <= (7'(mrow_ff + 1'b1) == ye7) ? S_POP : S_MARK_RD;
            end
            S_PUSH: begin
               if (sp_ff < SP_W'(STACK_DEPTH)) sp_ff <= sp_ff + 1'b1;
               push_ff <= push_ff + 1'b1;
               if (push_ff == 2'd3) state_ff <= S_POP;
            end
            S_OUT_RD: state_ff <= S_OUT_SEND;
            S_OUT_SEND: begin
               if (!rsp_stall) begin
                  if (orow_ff == LAST_ROW) begin
                     state_ff <= S_IDLE;
                  end else begin
                     orow_ff  <= orow_ff + 1'b1;
                     state_ff <= S_OUT_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Ports
   // ---------------------------------------------------------------------
   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = (state_ff == S_OUT_SEND);
   assign rsp_row_index = 6'(orow_ff);
   assign rsp_row_mask  = rd_ff;
   assign rsp_last_row  = (orow_ff == LAST_ROW);

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `TV_ASSERT(a_busy_while_sending, rsp_valid |-> req_stall, "row sent while taking requests")
   `TV_ASSERT(a_accept_starts_walk, req_acc |=> (state_ff == S_AREA && sp_ff == SP_W'(1)), "walk did not start with the root quad")
   `TV_ASSERT(a_xprod_done_awaited, xp_rsp.done |-> (state_ff == S_AREA_W || state_ff == S_CORNER_W || state_ff == S_EDGE_LO_W || state_ff == S_EDGE_HI_W), "product finished while sequencer not waiting")
   `TV_ASSERT_NEVER(a_stack_bound, sp_ff > SP_W'(STACK_DEPTH), "quad stack overflow")

endmodule

[design/tvis_xprod.sv]
// ----------------------------------------------------------------------------
// tvis_xprod
// Shared cross product unit: one multiplier, a*b then c*d, then a*b - c*d.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvis_xprod
   import tvis_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  xp_req_type xp_req,
   output xp_rsp_type xp_rsp
);

   typedef enum logic [1:0] {
      P_IDLE,
      P_MUL1,
      P_MUL2,
      P_SUB
   } phase_type;

   phase_type                 phase_ff;
   logic signed [OPW-1:0]     a_ff, b_ff, c_ff, d_ff;
   logic signed [2*OPW-1:0]   p_ff, q_ff;
   logic signed [RW-1:0]      res_ff;
   logic                      done_ff;
   logic signed [OPW-1:0]     mul_a, mul_b;
   logic signed [2*OPW-1:0]   mul_out;

   // single multiplier, operands picked by phase
   always_comb begin
      mul_a = (phase_ff == P_MUL2) ? c_ff : a_ff;
      mul_b = (phase_ff == P_MUL2) ? d_ff : b_ff;
      mul_out = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (phase_ff)
            P_IDLE: begin
               if (xp_req.start) begin
                  a_ff     <= xp_req.a;
                  b_ff     <= xp_req.b;
                  c_ff     <= xp_req.c;
                  d_ff     <= xp_req.d;
                  phase_ff <= P_MUL1;
               end
            end
            P_MUL1: begin
               p_ff     <= mul_out;
               phase_ff <= P_MUL2;
            end
            P_MUL2: begin
               q_ff     <= mul_out;
               phase_ff <= P_SUB;
            end
            P_SUB: begin
               res_ff   <= RW'(p_ff) - RW'(q_ff);
               done_ff  <= 1'b1;
               phase_ff <= P_IDLE;
            end
            default: phase_ff <= P_IDLE;
         endcase
      end
   end

   assign xp_rsp.done   = done_ff;
   assign xp_rsp.result = res_ff;

endmodule

[tb/tile_visibility_checker.sv]
// ----------------------------------------------------------------------------
// tile_visibility_checker
// Watches the request and row channels of the tile visibility block, bins each
// accepted triangle onto the tile map with its own quadtree walk, and compares
// every row transaction with the oldest predicted row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tile_visibility_checker
   import tvis_pkg::*;
#(
   parameter int MAP_SIZE      = 64,
   parameter int FRACTION_BITS = 8
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic signed [COORD_W-1:0] req_vertex_a_x,
   input  logic signed [COORD_W-1:0] req_vertex_a_y,
   input  logic signed [COORD_W-1:0] req_vertex_b_x,
   input  logic signed [COORD_W-1:0] req_vertex_b_y,
   input  logic signed [COORD_W-1:0] req_vertex_c_x,
   input  logic signed [COORD_W-1:0] req_vertex_c_y,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [5:0]                rsp_row_index,
   input  logic [63:0]               rsp_row_mask,
   input  logic                      rsp_last_row,
   output int                        error_count,
   output int                        rows_pending,
   output int                        rows_seen
);

   typedef struct {
      logic [5:0]  row;
      logic [63:0] mask;
      logic        last;
   } row_type;

   row_type     row_queue[$];
   longint      tri_v[6];
   logic [63:0] tile_map[64];

   assign rows_pending = row_queue.size();

   function automatic bit covers(longint px, longint py);
      longint area, w0, w1, w2;
      area = (tri_v[2]-tri_v[0])*(tri_v[5]-tri_v[1]) - (tri_v[4]-tri_v[0])*(tri_v[3]-tri_v[1]);
      w0 = (tri_v[2]-px)*(tri_v[5]-py) - (tri_v[4]-px)*(tri_v[3]-py);
      w1 = (tri_v[4]-px)*(tri_v[1]-py) - (tri_v[0]-px)*(tri_v[5]-py);
      w2 = (tri_v[0]-px)*(tri_v[3]-py) - (tri_v[2]-px)*(tri_v[1]-py);
      if (area > 0) return w0 > 0 && w1 > 0 && w2 > 0;
      if (area < 0) return w0 < 0 && w1 < 0 && w2 < 0;
      return 0;
   endfunction

   function automatic bit crosses(longint ua, longint va, longint ub, longint vb,
                                  longint line, longint lo, longint hi);
      longint d1, d2, den, num;
      d1 = va - line;
      d2 = vb - line;
      if (!((d1 < 0 && d2 > 0) || (d1 > 0 && d2 < 0))) return 0;
      den = d2 - d1;
      num = ub*den - d2*(ub - ua);
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      return lo*den <= num && num <= hi*den;
   endfunction

   function automatic bit touches(longint x0, longint y0, longint x1, longint y1);
      int j;
      for (int i = 0; i < 3; i++)
         if (tri_v[2*i] >= x0 && tri_v[2*i] <= x1 && tri_v[2*i+1] >= y0 &&
             tri_v[2*i+1] <= y1) return 1;
      for (int i = 0; i < 3; i++) begin
         j = (i == 2) ? 0 : i + 1;
         if (crosses(tri_v[2*i], tri_v[2*i+1], tri_v[2*j], tri_v[2*j+1], y0, x0, x1) ||
             crosses(tri_v[2*i], tri_v[2*i+1], tri_v[2*j], tri_v[2*j+1], y1, x0, x1) ||
             crosses(tri_v[2*i+1], tri_v[2*i], tri_v[2*j+1], tri_v[2*j], x0, y0, y1) ||
             crosses(tri_v[2*i+1], tri_v[2*i], tri_v[2*j+1], tri_v[2*j], x1, y0, y1))
            return 1;
      end
      return 0;
   endfunction

   function automatic void fill(int x, int y, int size);
      for (int j = y; j < y + size; j++)
         for (int i = x; i < x + size; i++)
            if (i < MAP_SIZE && j < MAP_SIZE) tile_map[j][i] = 1'b1;
   endfunction

   // quadtree walk with an unbounded work list; order does not change the map
   function automatic void bin_triangle();
      quad_type work[$];
      quad_type q;
      int       size, half, root_lvl;
      longint   s, x0, y0, x1, y1;
      bit       c0, c1, c2, c3;
      s = longint'(1) << FRACTION_BITS;
      root_lvl = 0;
      while ((1 << root_lvl) < MAP_SIZE && root_lvl < 6) root_lvl++;
      foreach (tile_map[r]) tile_map[r] = '0;
      work.insert(work.size(), '{lvl: root_lvl[2:0], y: 6'd0, x: 6'd0});
      while (work.size() > 0) begin
         q = work.pop_back();
         size = 1 << q.lvl;
         x0 = q.x * s;
         y0 = q.y * s;
         x1 = (q.x + size) * s;
         y1 = (q.y + size) * s;
         c0 = covers(x0, y0);
         c1 = covers(x1, y0);
         c2 = covers(x1, y1);
         c3 = covers(x0, y1);
         if (c0 && c1 && c2 && c3) begin
            fill(q.x, q.y, size);
         end else if (c0 || c1 || c2 || c3 || touches(x0, y0, x1, y1)) begin
            if (size < 2) begin
               if (c0 || c1 || c2 || c3) fill(q.x, q.y, 1);
            end else begin
               half = size >> 1;
               work.insert(work.size(),
                           '{lvl: q.lvl - 3'd1, y: q.y[5:0], x: q.x[5:0]});
               work.insert(work.size(),
                           '{lvl: q.lvl - 3'd1, y: q.y[5:0], x: 6'(q.x + half)});
               work.insert(work.size(),
                           '{lvl: q.lvl - 3'd1, y: 6'(q.y + half), x: q.x[5:0]});
               work.insert(work.size(),
                           '{lvl: q.lvl - 3'd1, y: 6'(q.y + half), x: 6'(q.x + half)});
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      row_type got, want;
      if (reset) begin
         error_count <= 0;
         rows_seen <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            tri_v[0] = req_vertex_a_x;
            tri_v[1] = req_vertex_a_y;
            tri_v[2] = req_vertex_b_x;
            tri_v[3] = req_vertex_b_y;
            tri_v[4] = req_vertex_c_x;
            tri_v[5] = req_vertex_c_y;
            bin_triangle();
            for (int r = 0; r < MAP_SIZE && r < 64; r++)
               row_queue.insert(row_queue.size(),
                                '{row: r[5:0], mask: tile_map[r],
                                  last: (r == MAP_SIZE - 1 || r == 63)});
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{row: rsp_row_index, mask: rsp_row_mask, last: rsp_last_row};
            rows_seen <= rows_seen + 1;
            if (row_queue.size() == 0) begin
               if (error_count < 10)
                  $display("%0t: unexpected row transaction row %0d mask %h", $realtime,
                           got.row, got.mask);
               error_count <= error_count + 1;
            end else begin
               want = row_queue.pop_front();
               if (got.row !== want.row || got.mask !== want.mask || got.last !== want.last) begin
                  if (error_count < 10)
                     $display("%0t: row mismatch: expected row %0d mask %h last %b, got row %0d mask %h last %b",
                              $realtime, want.row, want.mask, want.last, got.row, got.mask, got.last);
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

endmodule

[tb/tb_triangle_tile_visibility.sv]
// ----------------------------------------------------------------------------
// tb_triangle_tile_visibility
// Stimulus and verdict for the tile visibility block: directed triangles at
// the field extremes, degenerate, tiny, off-map and sliver shapes, then random
// triangles mostly scaled to land on the map, under three idle/stall profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_triangle_tile_visibility
   import tvis_pkg::*;
();

   localparam int MAP_SIZE      = 64;
   localparam int FRACTION_BITS = 8;
   localparam int RANDOM_ITEMS  = 128;

   logic clock, reset;
   logic req_valid, req_stall;
   logic signed [COORD_W-1:0] vtx[6];
   logic rsp_valid, rsp_stall;
   logic [5:0]  rsp_row_index;
   logic [63:0] rsp_row_mask;
   logic        rsp_last_row;
   int error_count, rows_pending, rows_seen;
   int send_idle_pct, recv_stall_pct;
   int triangles_sent;

   triangle_tile_visibility #(.MAP_SIZE(MAP_SIZE), .FRACTION_BITS(FRACTION_BITS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_vertex_a_x(vtx[0]), .req_vertex_a_y(vtx[1]),
      .req_vertex_b_x(vtx[2]), .req_vertex_b_y(vtx[3]),
      .req_vertex_c_x(vtx[4]), .req_vertex_c_y(vtx[5]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_row_index(rsp_row_index), .rsp_row_mask(rsp_row_mask),
      .rsp_last_row(rsp_last_row)
   );

   tile_visibility_checker #(.MAP_SIZE(MAP_SIZE), .FRACTION_BITS(FRACTION_BITS)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_vertex_a_x(vtx[0]), .req_vertex_a_y(vtx[1]),
      .req_vertex_b_x(vtx[2]), .req_vertex_b_y(vtx[3]),
      .req_vertex_c_x(vtx[4]), .req_vertex_c_y(vtx[5]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_row_index(rsp_row_index), .rsp_row_mask(rsp_row_mask),
      .rsp_last_row(rsp_last_row),
      .error_count(error_count), .rows_pending(rows_pending), .rows_seen(rows_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver: random stall at the current profile's rate, redrawn every edge
   initial rsp_stall = 1'b1;
   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   // one transaction: optional idle gap, then hold valid until accepted;
   // valid stays up afterwards so back-to-back sends need one assignment
   task automatic send_triangle(input logic signed [COORD_W-1:0] v[6]);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      foreach (vtx[i]) vtx[i] <= v[i];
      do @(posedge clock); while (req_stall);
      triangles_sent++;
   endtask

   // drop valid and wait until every predicted row has come back
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (rows_pending != 0) @(posedge clock);
   endtask

   // random vertex: mostly near the map with fractions, some on whole tiles, some wild
   function automatic logic signed [COORD_W-1:0] pick_coord();
      int sel;
      sel = $urandom_range(99);
      if (sel < 70) return COORD_W'($urandom_range(0, (MAP_SIZE + 8) << 8) - (4 << 8));
      if (sel < 85) return COORD_W'($urandom_range(0, MAP_SIZE) << 8);
      return COORD_W'($urandom);
   endfunction

   task automatic send_directed();
      logic signed [COORD_W-1:0] t[6];
      t = '{default: 24'sh800000}; send_triangle(t);
      t = '{default: 24'sh7FFFFF}; send_triangle(t);
      // huge triangle covering the whole map, both windings
      t = '{24'sh800000, 24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh000000, 24'sh7FFFFF};
      send_triangle(t);
      t = '{24'sh800000, 24'sh800000, 24'sh000000, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000};
      send_triangle(t);
      // degenerate: collinear and a repeated vertex
      t = '{24'sh000100, 24'sh000100, 24'sh002000, 24'sh002000, 24'sh003000, 24'sh003000};
      send_triangle(t);
      t = '{24'sh000500, 24'sh000500, 24'sh000500, 24'sh000500, 24'sh003000, 24'sh001000};
      send_triangle(t);
      // a small triangle inside one tile, and a half-map one on tile corners
      t = '{24'sh000A40, 24'sh000A40, 24'sh000AC0, 24'sh000A40, 24'sh000A80, 24'sh000AC0};
      send_triangle(t);
      t = '{24'sh000000, 24'sh000000, 24'sh004000, 24'sh000000, 24'sh000000, 24'sh004000};
      send_triangle(t);
      // off the map on the negative side and past the far edge
      t = '{-24'sh1000, -24'sh1000, -24'sh0100, -24'sh2000, -24'sh3000, -24'sh0100};
      send_triangle(t);
      t = '{24'sh003F80, 24'sh003F80, 24'sh005000, 24'sh003F80, 24'sh003F80, 24'sh005000};
      send_triangle(t);
      // sliver crossing the whole map diagonal, then a large fractional one
      t = '{-24'sh0800, 24'sh000000, 24'sh004800, 24'sh004000, 24'sh004800, 24'sh004080};
      send_triangle(t);
      t = '{24'sh0000AB, 24'sh003355, 24'sh002CCD, 24'sh000155, 24'sh003E01, 24'sh003FFF};
      send_triangle(t);
   endtask

   initial begin
      logic signed [COORD_W-1:0] t[6];
      reset = 1'b1;
      req_valid = 1'b0;
      vtx = '{default: '0};
      triangles_sent = 0;
      send_idle_pct = 34;
      recv_stall_pct = 53;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_directed();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 53;
            recv_stall_pct = 34;
            // hold off until every predicted row has drained
            drain();
         end
         if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         foreach (t[i]) t[i] = pick_coord();
         send_triangle(t);
      end

      drain();
      repeat (200) @(posedge clock);
      $display("Binned %0d triangles (extremes, degenerate, off-map, random) into %0d rows",
               triangles_sent, rows_seen);
      $display("under three idle/stall profiles; mismatches: %0d", error_count);
      if (error_count == 0 && rows_pending == 0)
         $display("[triangle_tile_visibility] OK");
      else
         $display("[triangle_tile_visibility] ERROR");
      $finish;
   end

   // even a walk over every quad of the tree for each of the 140 triangles
   // still finishes well inside this limit
   initial begin
      #10s;
      $display("[triangle_tile_visibility] ERROR");
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/tvis_pkg.sv
design/tvis_xprod.sv
design/triangle_tile_visibility.sv
tb/tile_visibility_checker.sv
tb/tb_triangle_tile_visibility.sv
